### rtl/rbht_pkg.sv
// Package: shared types and constants for the bind and hop table block.
`default_nettype none
package rbht_pkg;
    localparam logic [1:0] FUNC_BYTE    = 2'd0;
    localparam logic [1:0] FUNC_HOP     = 2'd1;
    localparam logic [1:0] FUNC_RESTART = 2'd2;

    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_COLLECT = 2'd1;
    localparam logic [1:0] PH_DONE    = 2'd2;

    localparam logic [7:0] CRC_OK_BIT   = 8'h80;
    localparam logic [7:0] BIND_MARK    = 8'h01;
    localparam logic [7:0] INDEX_END_OK = 8'h2D;
    localparam logic [7:0] INDEX_LIMIT  = 8'd120;
    localparam logic [7:0] INDEX_STEP   = 8'h05;
    localparam int         MIN_LEN      = 13;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] data_byte;
        logic       last;
        logic [7:0] hop_skip;
    } t_in;

    typedef struct packed {
        logic [1:0]  phase;
        logic        bind_done;
        logic [7:0]  hop_channel;
        logic        hop_error;
        logic [15:0] transmitter_id;
        logic [7:0]  receiver_number;
        logic [7:0]  list_length;
    } t_out;

    // datapath operations
    localparam logic [3:0] OP_NONE    = 4'd0;
    localparam logic [3:0] OP_LATCH   = 4'd1;  // capture item, store byte
    localparam logic [3:0] OP_PRD     = 4'd2;  // issue packet read at r_paddr
    localparam logic [3:0] OP_HDR     = 4'd3;  // capture header byte
    localparam logic [3:0] OP_ENTRY   = 4'd4;  // process one hop entry
    localparam logic [3:0] OP_MODSTEP = 4'd5;  // one step of modulo
    localparam logic [3:0] OP_HRD     = 4'd6;  // read hop store
    localparam logic [3:0] OP_FINISH  = 4'd7;  // commit packet result
    localparam logic [3:0] OP_OUT     = 4'd8;  // set hop channel and error
    localparam logic [3:0] OP_LOAD    = 4'd9;  // load result register

    typedef struct packed {
        logic [3:0] op;
        logic [3:0] sel;   // header slot or entry number
    } t_cmd;

    typedef struct packed {
        logic       pkt_ok;    // last byte, length and overflow fine
        logic       hdr_ok;    // checks pass, go on with entries
        logic       first;     // first bind packet
        logic       ended;     // entry loop stopped
        logic       mod_done;
        logic       empty;
    } t_sts;
endpackage
`default_nettype wire

### rtl/rbht_if.sv
// Interfaces: valid/ready channels for items and results.
`default_nettype none
interface rbht_in_if;
    logic            valid;
    logic            ready;
    rbht_pkg::t_in   data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface rbht_out_if;
    logic            valid;
    logic            ready;
    rbht_pkg::t_out  data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/rbht_ram.sv
// Generic single-port-write, single-read RAM with registered read.
`default_nettype none
module rbht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### rtl/rbht_dp.sv
// Datapath: packet and hop stores, bind state, modulo unit, result fields.
`default_nettype none
module rbht_dp #(
    parameter int PACKET_DEPTH = 64,
    parameter int HOP_DEPTH    = 128
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire rbht_pkg::t_in i_item,
    input  wire rbht_pkg::t_cmd i_cmd,
    output rbht_pkg::t_sts     o_sts,
    output rbht_pkg::t_out     o_res
);
    import rbht_pkg::*;
    localparam int PAW = $clog2(PACKET_DEPTH);
    localparam int HAW = $clog2(HOP_DEPTH);
    localparam int CW  = $clog2(PACKET_DEPTH + 1);

    t_in         r_item;
    logic [CW-1:0] r_cnt;
    logic        r_ovf;
    logic [CW-1:0] r_len;
    logic        r_lenok;
    logic [1:0]  r_phase;
    logic [7:0]  r_idx;
    logic [7:0]  r_hcnt;
    logic [7:0]  r_pos;
    logic [15:0] r_id;
    logic [7:0]  r_rcv;
    logic [7:0]  r_crcb, r_b2, r_b3, r_b4, r_b5, r_b12, r_tail;
    logic        r_ended, r_done;
    logic [8:0]  r_rem;
    logic [7:0]  r_chan;
    logic        r_err;
    logic [PAW-1:0] r_paddr;
    t_out        r_res;

    logic [7:0]  prd, hrd;
    logic        pwe, hwe;
    logic [HAW-1:0] hwaddr;
    logic [7:0]  hwdata;

    // packet read address per header slot
    logic [CW:0] slot_addr;
    always_comb begin
        unique case (i_cmd.sel)
            4'd0:    slot_addr = {1'b0, r_len} - 1'b1;
            4'd1:    slot_addr = (CW+1)'(2);
            4'd2:    slot_addr = (CW+1)'(3);
            4'd3:    slot_addr = (CW+1)'(4);
            4'd4:    slot_addr = (CW+1)'(5);
            4'd5:    slot_addr = (CW+1)'(12);
            4'd6:    slot_addr = {1'b0, r_len} - (CW+1)'(3);
            default: slot_addr = (CW+1)'(6) + (CW+1)'(i_cmd.sel - 4'd7);
        endcase
    end

    assign pwe = (i_cmd.op == OP_LATCH) && (i_item.func == FUNC_BYTE)
               && (r_cnt < CW'(PACKET_DEPTH));

    rbht_ram #(.WIDTH(8), .DEPTH(PACKET_DEPTH)) u_pkt (
        .i_clk(i_clk), .i_we(pwe), .i_waddr(r_cnt[PAW-1:0]), .i_wdata(i_item.data_byte),
        .i_raddr(r_paddr), .o_rdata(prd)
    );

    // entry handling
    logic [7:0] ent_n;
    logic [8:0] ent_pos;
    logic       ent_stop;
    assign ent_n    = {4'd0, i_cmd.sel};
    assign ent_pos  = {1'b0, (r_phase == PH_IDLE) ? 8'd0 : r_idx} + {1'b0, ent_n};
    assign ent_stop = (r_phase == PH_COLLECT) && ((prd == r_tail) || (prd == 8'd0))
                    && (r_idx >= INDEX_END_OK);
    assign hwe    = (i_cmd.op == OP_ENTRY) && !r_ended && !ent_stop
                  && (ent_pos < 9'(HOP_DEPTH));
    assign hwaddr = ent_pos[HAW-1:0];
    assign hwdata = prd;

    rbht_ram #(.WIDTH(8), .DEPTH(HOP_DEPTH)) u_hop (
        .i_clk(i_clk), .i_we(hwe), .i_waddr(hwaddr), .i_wdata(hwdata),
        .i_raddr(r_rem[HAW-1:0]), .o_rdata(hrd)
    );

    logic hdr_ok;
    always_comb begin
        hdr_ok = r_lenok && ((r_crcb & CRC_OK_BIT) != 8'd0) && (r_b2 == BIND_MARK);
        if (r_phase == PH_IDLE) hdr_ok = hdr_ok && (r_b5 == 8'd0);
        else hdr_ok = hdr_ok && (r_phase == PH_COLLECT) && (r_b3 == r_id[7:0])
                      && (r_b4 == r_id[15:8]) && (r_b5 == r_idx);
    end

    logic [8:0] idx_nxt;
    assign idx_nxt = {1'b0, r_idx} + {1'b0, INDEX_STEP};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
            r_phase <= PH_IDLE;
            r_idx   <= INDEX_STEP;
            r_hcnt  <= 8'd0;
            r_pos   <= 8'd0;
            r_id    <= 16'd0;
            r_rcv   <= 8'd0;
            r_ended <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            unique case (i_cmd.op)
                OP_LATCH: begin
                    r_item  <= i_item;
                    r_done  <= 1'b0;
                    r_ended <= 1'b0;
                    r_err   <= 1'b0;
                    r_chan  <= 8'd0;
                    if (i_item.func == FUNC_BYTE) begin
                        logic [CW-1:0] c;
                        logic          o;
                        c = r_cnt;
                        o = r_ovf;
                        if (r_cnt < CW'(PACKET_DEPTH)) c = r_cnt + 1'b1;
                        else o = 1'b1;
                        r_len   <= c;
                        r_lenok <= !o && (c >= CW'(MIN_LEN));
                        if (i_item.last) begin
                            r_cnt <= '0;
                            r_ovf <= 1'b0;
                        end else begin
                            r_cnt <= c;
                            r_ovf <= o;
                        end
                    end else if (i_item.func == FUNC_RESTART) begin
                        r_phase <= PH_IDLE;
                        r_idx   <= INDEX_STEP;
                        r_hcnt  <= 8'd0;
                        r_cnt   <= '0;
                        r_ovf   <= 1'b0;
                    end
                    r_rem[8] <= 1'b0;
                    r_rem[7:0] <= r_pos + i_item.hop_skip;
                end
                OP_PRD: r_paddr <= slot_addr[PAW-1:0];
                OP_HDR: begin
                    unique case (i_cmd.sel)
                        4'd0:    r_crcb <= prd;
                        4'd1:    r_b2   <= prd;
                        4'd2:    r_b3   <= prd;
                        4'd3:    r_b4   <= prd;
                        4'd4:    r_b5   <= prd;
                        4'd5:    r_b12  <= prd;
                        default: r_tail <= prd;
                    endcase
                end
                OP_ENTRY: begin
                    if (!r_ended && ent_stop) begin
                        r_ended <= 1'b1;
                        r_hcnt  <= r_idx + ent_n;
                        r_phase <= PH_DONE;
                        r_done  <= 1'b1;
                    end
                end
                OP_FINISH: begin
                    if (r_phase == PH_IDLE) begin
                        r_id    <= {r_b4, r_b3};
                        r_rcv   <= r_b12;
                        r_phase <= PH_COLLECT;
                    end else if (!r_ended) begin
                        r_idx <= idx_nxt[7:0];
                        if (idx_nxt > {1'b0, INDEX_LIMIT}) begin
                            r_hcnt  <= 8'd0;
                            r_phase <= PH_DONE;
                            r_done  <= 1'b1;
                        end
                    end
                end
                OP_MODSTEP: begin
                    if (r_rem >= {1'b0, r_hcnt}) r_rem <= r_rem - {1'b0, r_hcnt};
                end
                OP_HRD: r_pos <= r_rem[7:0];
                OP_OUT: begin
                    if (r_item.func == FUNC_HOP) begin
                        if (r_hcnt == 8'd0) r_err <= 1'b1;
                        else r_chan <= (r_rem < 9'(HOP_DEPTH)) ? hrd : 8'd0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        r_res.phase           = r_phase;
        r_res.bind_done       = r_done;
        r_res.hop_channel     = r_chan;
        r_res.hop_error       = r_err;
        r_res.transmitter_id  = r_id;
        r_res.receiver_number = r_rcv;
        r_res.list_length     = r_hcnt;
    end
    assign o_res = r_res;

    assign o_sts.pkt_ok   = r_item.last && r_lenok;
    assign o_sts.hdr_ok   = hdr_ok;
    assign o_sts.first    = (r_phase == PH_IDLE);
    assign o_sts.ended    = r_ended;
    assign o_sts.mod_done = (r_rem < {1'b0, r_hcnt});
    assign o_sts.empty    = (r_hcnt == 8'd0);
endmodule
`default_nettype wire

### rtl/rbht_ctrl.sv
// Controller: sequences item capture, packet checks, entry walk, modulo and output.
`default_nettype none
module rbht_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire logic [1:0]     i_func,
    input  wire rbht_pkg::t_sts i_sts,
    output rbht_pkg::t_cmd      o_cmd,
    output logic                o_out_valid,
    input  wire logic           i_out_ready
);
    import rbht_pkg::*;
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DISP  = 4'd1;
    localparam logic [3:0] S_HRD   = 4'd2;  // issue header read
    localparam logic [3:0] S_HWAIT = 4'd3;
    localparam logic [3:0] S_HCAP  = 4'd4;
    localparam logic [3:0] S_CHK   = 4'd5;
    localparam logic [3:0] S_ERD   = 4'd6;
    localparam logic [3:0] S_EWAIT = 4'd7;
    localparam logic [3:0] S_ECAP  = 4'd8;
    localparam logic [3:0] S_FIN   = 4'd9;
    localparam logic [3:0] S_MOD   = 4'd10;
    localparam logic [3:0] S_HOPRD = 4'd11;
    localparam logic [3:0] S_HOPW  = 4'd12;
    localparam logic [3:0] S_OUT   = 4'd13;
    localparam logic [3:0] S_SEND  = 4'd14;

    logic [3:0] r_state, n_state;
    logic [3:0] r_sel, n_sel;
    logic       r_ov, n_ov;

    assign o_in_ready  = (r_state == S_IDLE) && !(r_ov && !i_out_ready);
    assign o_out_valid = r_ov;

    always_comb begin
        n_state = r_state;
        n_sel   = r_sel;
        n_ov    = r_ov && !i_out_ready;
        o_cmd.op  = OP_NONE;
        o_cmd.sel = r_sel;
        unique case (r_state)
            S_IDLE: if (o_in_ready && i_in_valid) begin
                o_cmd.op = OP_LATCH;
                n_state  = S_DISP;
            end
            S_DISP: begin
                n_sel = 4'd0;
                if (i_func == FUNC_BYTE && i_sts.pkt_ok) n_state = S_HRD;
                else if (i_func == FUNC_HOP && !i_sts.empty) n_state = S_MOD;
                else n_state = S_OUT;
            end
            S_HRD: begin
                o_cmd.op = OP_PRD;
                n_state  = S_HWAIT;
            end
            S_HWAIT: n_state = S_HCAP;
            S_HCAP: begin
                o_cmd.op = OP_HDR;
                if (r_sel == 4'd6) n_state = S_CHK;
                else begin
                    n_sel   = r_sel + 4'd1;
                    n_state = S_HRD;
                end
            end
            S_CHK: begin
                n_sel   = 4'd7;
                n_state = i_sts.hdr_ok ? S_ERD : S_OUT;
            end
            S_ERD: begin
                o_cmd.op = OP_PRD;
                n_state  = S_EWAIT;
            end
            S_EWAIT: n_state = S_ECAP;
            S_ECAP: begin
                o_cmd.op  = OP_ENTRY;
                o_cmd.sel = r_sel - 4'd7;
                if (r_sel == 4'd11) n_state = S_FIN;
                else begin
                    n_sel   = r_sel + 4'd1;
                    n_state = S_ERD;
                end
            end
            S_FIN: begin
                o_cmd.op = OP_FINISH;
                n_state  = S_OUT;
            end
            S_MOD: begin
                o_cmd.op = OP_MODSTEP;
                if (i_sts.mod_done) n_state = S_HOPRD;
            end
            S_HOPRD: begin
                o_cmd.op = OP_HRD;
                n_state  = S_HOPW;
            end
            S_HOPW: n_state = S_OUT;
            S_OUT: begin
                o_cmd.op = OP_OUT;
                n_state  = S_SEND;
            end
            S_SEND: if (!r_ov || i_out_ready) begin
                o_cmd.op = OP_LOAD;
                n_ov     = 1'b1;
                n_state  = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sel   <= 4'd0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
            r_ov    <= n_ov;
        end
    end
endmodule
`default_nettype wire

### rtl/radio_bind_hop_table.sv
// Top level: radio bind and hop table receiver.
// A byte, restart or empty-list hop goes straight to the output step; a last byte
// reads the header and, only when the checks pass, walks the five entries
// (7 header and 5 entry reads); a hop runs subtract steps, then reads the hop store.
// One item at a time, accepted only in idle after the result loads; a result still
// waiting for ready holds the input off. Sync active-low reset; stores not cleared.
`default_nettype none
module radio_bind_hop_table #(
    parameter int PACKET_DEPTH = 64,
    parameter int HOP_DEPTH    = 128
) (
    input wire logic  i_clk,
    input wire logic  i_rst_n,
    rbht_in_if.sink   i_in,
    rbht_out_if.source o_out
);
    import rbht_pkg::*;
    t_cmd cmd;
    t_sts sts;
    t_out res;
    t_out r_out;
    logic fire_in;

    // item fields taken live only on the latch cycle; later use the captured copy
    t_in item_mux;
    logic [1:0] r_func;
    always_ff @(posedge i_clk) if (fire_in) r_func <= i_in.data.func;
    assign fire_in = i_in.valid && i_in.ready;
    always_comb begin
        item_mux = i_in.data;
    end

    rbht_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in.valid), .o_in_ready(i_in.ready),
        .i_func(r_func), .i_sts(sts), .o_cmd(cmd),
        .o_out_valid(o_out.valid), .i_out_ready(o_out.ready)
    );

    rbht_dp #(.PACKET_DEPTH(PACKET_DEPTH), .HOP_DEPTH(HOP_DEPTH)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_item(item_mux), .i_cmd(cmd),
        .o_sts(sts), .o_res(res)
    );

    // result register loads on the edge where the controller raises valid
    always_ff @(posedge i_clk) begin
        if (cmd.op == OP_LOAD) r_out <= res;
    end
    assign o_out.data = r_out;

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire_in |=> !i_in.ready) else $error("ready while busy");
    a_err_no_chan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.data.hop_error |-> o_out.data.hop_channel == 8'd0)
        else $error("hop error with channel");
    a_done_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.data.bind_done |-> o_out.data.phase == PH_DONE)
        else $error("done without complete phase");
    a_func_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire_in |=> r_func == $past(i_in.data.func)) else $error("func lost");
endmodule
`default_nettype wire
